/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on clk_i, with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check on every rising edge while out of reset.
`define ASSERT_P(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check on every rising edge, reset included.
`define ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_P(lbl, prop, msg)
`define ASSERT_NR(lbl, prop, msg)
`endif

`endif

/* hw/rtl/izt_pkg.sv */
// ----------------------------------------------------------------------------
// izt_pkg
// Shared types and constants of the irrigation zone timer controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package izt_pkg;

  localparam int unsigned NUM_SCHED   = 5;
  localparam int unsigned NUM_ZONES   = 4;
  localparam int unsigned SCHED_IDX_W = $clog2(NUM_SCHED);
  localparam int unsigned CFG_ADDR_W  = $clog2(NUM_SCHED + 1);
  localparam int unsigned CFG_DATA_W  = 31;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_DEFAULT_MIN = CFG_ADDR_W'(NUM_SCHED);

  // Operation codes
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_SCHED  = 3'd1;
  localparam logic [2:0] OP_MANUAL = 3'd2;
  localparam logic [2:0] OP_KEY    = 3'd3;
  localparam logic [2:0] OP_STOP   = 3'd4;

  // Alert codes
  localparam logic [1:0] ALERT_NONE   = 2'd0;
  localparam logic [1:0] ALERT_PEST   = 2'd1;
  localparam logic [1:0] ALERT_BIO    = 2'd2;
  localparam logic [1:0] ALERT_ACTIVE = 2'd3;

  localparam logic [13:0] SEC_PER_MIN = 14'd60;
  localparam logic [5:0]  SEC_RELOAD  = 6'd59;
  localparam logic [7:0]  DEFAULT_MIN_RST = 8'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK_END,
    ST_SCHED,
    ST_DONE
  } izt_state_e;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_TICK,
    ACT_TICK_END,
    ACT_SCHED,
    ACT_MANUAL,
    ACT_KEY,
    ACT_STOP,
    ACT_OUT
  } izt_act_e;

  typedef struct packed {
    izt_act_e               act;
    logic [SCHED_IDX_W-1:0] sched_idx;
  } izt_cmd_t;

  typedef struct packed {
    logic [2:0] op;
  } izt_status_t;

  typedef struct packed {
    logic       biopest_busy;
    logic       pesticide_busy;
    logic [5:0] minute_now;
    logic [4:0] hour_now;
    logic [2:0] weekday;
    logic [7:0] duration_minutes;
    logic [2:0] zone;
  } izt_item_t;

  typedef struct packed {
    logic [1:0]           alert;
    logic [5:0]           seconds_left;
    logic [7:0]           minutes_left;
    logic                 pump_on;
    logic [NUM_ZONES-1:0] valve_mask;
    logic                 watering_on;
  } izt_result_t;

endpackage

/* hw/rtl/izt_ctrl.sv */
// ----------------------------------------------------------------------------
// izt_ctrl
// Sequencer: accepts an item, steps the datapath through it, hands off result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module izt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  izt_pkg::izt_status_t status_i,
  output izt_pkg::izt_cmd_t    cmd_o
);
  import izt_pkg::*;

  localparam logic [SCHED_IDX_W-1:0] LAST_IDX = SCHED_IDX_W'(NUM_SCHED - 1);

  izt_state_e             state_q, state_d;
  logic [SCHED_IDX_W-1:0] idx_q, idx_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (status_i.op)
          OP_TICK:  state_d = ST_TICK_END;
          OP_SCHED: state_d = ST_SCHED;
          default:  state_d = ST_DONE;
        endcase
      end
      ST_TICK_END: state_d = ST_DONE;
      ST_SCHED: begin
        if (idx_q == LAST_IDX) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.act       = ACT_NONE;
    cmd_o.sched_idx = idx_q;
    in_ready_o      = 1'b0;
    idx_d           = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.act = ACT_LOAD;
      end
      ST_EXEC: begin
        idx_d = '0;
        unique case (status_i.op)
          OP_TICK:   cmd_o.act = ACT_TICK;
          OP_MANUAL: cmd_o.act = ACT_MANUAL;
          OP_KEY:    cmd_o.act = ACT_KEY;
          OP_STOP:   cmd_o.act = ACT_STOP;
          default:   cmd_o.act = ACT_NONE;
        endcase
      end
      ST_TICK_END: cmd_o.act = ACT_TICK_END;
      ST_SCHED: begin
        cmd_o.act = ACT_SCHED;
        idx_d     = idx_q + 1'b1;
      end
      ST_DONE: begin
        if (out_free) cmd_o.act = ACT_OUT;
      end
      default: cmd_o.act = ACT_NONE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.act == ACT_OUT) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  `ASSERT_NR(a_rst_idle, !rst_ni |=> (state_q == ST_IDLE && !out_valid_q), "not idle in reset")
  `ASSERT_P(a_accept_exec, in_valid_i && in_ready_o |=> state_q == ST_EXEC, "accept lost")
  `ASSERT_P(a_idx_range, state_q == ST_SCHED |-> idx_q <= LAST_IDX, "schedule index overrun")
  `ASSERT_P(a_out_free, cmd_o.act == ACT_OUT |-> (!out_valid_q || out_ready_i), "result overwrite")

endmodule

/* hw/rtl/izt_datapath.sv */
// ----------------------------------------------------------------------------
// izt_datapath
// Run state, schedule registers, countdown and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module izt_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [izt_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [izt_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic [2:0]                          op_i,
  input  izt_pkg::izt_item_t                  item_i,
  input  izt_pkg::izt_cmd_t                   cmd_i,
  output izt_pkg::izt_status_t                status_o,
  output izt_pkg::izt_result_t                result_o
);
  import izt_pkg::*;

  typedef struct packed {
    logic [7:0] mins;
    logic [5:0] secs;
  } izt_count_t;

  localparam logic [NUM_ZONES-1:0] ALL_ZONES = '1;

  // Decrement seconds while both fields are nonzero; roll into minutes.
  function automatic izt_count_t count_step(izt_count_t c);
    izt_count_t r;
    logic [5:0] s;
    r = c;
    s = c.secs - 6'd1;
    if (c.secs != '0 && c.mins != '0) begin
      if (s == '0) begin
        r.mins = c.mins - 8'd1;
        r.secs = SEC_RELOAD;
      end else begin
        r.secs = s;
      end
    end
    return r;
  endfunction

  function automatic logic [NUM_ZONES-1:0] zone_bits(logic [2:0] z);
    logic [NUM_ZONES-1:0] m;
    m = '0;
    if (z == '0) begin
      m = ALL_ZONES;
    end else if (32'(z) <= NUM_ZONES) begin
      m = NUM_ZONES'(1) << (z - 3'd1);
    end
    return m;
  endfunction

  logic [CFG_DATA_W-1:0] sched_q [NUM_SCHED];
  logic [7:0]            default_min_q;

  logic [2:0]            op_q;
  izt_item_t             item_q;
  izt_result_t           out_q;

  logic                  active_q, active_d;
  logic [NUM_ZONES-1:0]  valves_q, valves_d;
  logic                  pump_q, pump_d;
  logic [13:0]           elapsed_q, elapsed_d;
  logic [7:0]            run_min_q, run_min_d;
  izt_count_t            cnt_q, cnt_d;
  logic [1:0]            alert_q, alert_d;

  logic [13:0]           run_limit;
  logic [CFG_DATA_W-1:0] sched_r;
  logic [7:0]            day_mask;
  logic                  sched_hit;
  logic                  pest_busy, bio_busy;
  logic [1:0]            refuse;
  logic [NUM_ZONES-1:0]  zb;
  logic [NUM_ZONES-1:0]  stop_valves;
  logic [7:0]            start_min;

  assign run_limit = {6'd0, run_min_q} * SEC_PER_MIN;

  assign sched_r   = sched_q[cmd_i.sched_idx];
  assign day_mask  = {1'b0, sched_r[7:1]};
  assign sched_hit = sched_r[0] && day_mask[item_q.weekday]
                     && (sched_r[12:8] == item_q.hour_now)
                     && (sched_r[18:13] == item_q.minute_now);

  assign pest_busy = item_q.pesticide_busy;
  assign bio_busy  = item_q.biopest_busy;
  assign zb        = zone_bits(item_q.zone);
  assign stop_valves = valves_q & ~zb;

  always_comb begin
    if (pest_busy)     refuse = ALERT_PEST;
    else if (bio_busy) refuse = ALERT_BIO;
    else if (active_q) refuse = ALERT_ACTIVE;
    else               refuse = ALERT_NONE;
  end

  always_comb begin
    active_d  = active_q;
    valves_d  = valves_q;
    pump_d    = pump_q;
    elapsed_d = elapsed_q;
    run_min_d = run_min_q;
    cnt_d     = cnt_q;
    alert_d   = alert_q;
    start_min = '0;
    unique case (cmd_i.act)
      ACT_LOAD: alert_d = ALERT_NONE;
      ACT_TICK: begin
        if (active_q) begin
          cnt_d     = count_step(cnt_q);
          elapsed_d = elapsed_q + 14'd1;
        end
      end
      ACT_TICK_END: begin
        if (active_q && elapsed_q >= run_limit) begin
          elapsed_d = '0;
          active_d  = 1'b0;
          pump_d    = 1'b0;
          valves_d  = '0;
        end
      end
      ACT_SCHED: begin
        if (sched_hit) begin
          valves_d  = sched_r[19 +: NUM_ZONES] & ALL_ZONES;
          run_min_d = sched_r[30:23];
          if (!active_q && !pest_busy && !bio_busy) begin
            active_d   = 1'b1;
            pump_d     = 1'b1;
            elapsed_d  = '0;
            cnt_d.mins = sched_r[30:23] - 8'd1;
            cnt_d.secs = SEC_RELOAD;
          end
        end
      end
      ACT_MANUAL: begin
        alert_d = refuse;
        if (refuse == ALERT_ACTIVE) begin
          valves_d = valves_q | zb;
        end else if (refuse == ALERT_NONE) begin
          active_d   = 1'b1;
          pump_d     = 1'b1;
          elapsed_d  = '0;
          run_min_d  = item_q.duration_minutes;
          cnt_d.mins = item_q.duration_minutes - 8'd1;
          cnt_d.secs = SEC_RELOAD;
          valves_d   = valves_q | zb;
        end
      end
      ACT_KEY: begin
        alert_d = refuse;
        if (refuse == ALERT_NONE) begin
          start_min = default_min_q - 8'd1;
          active_d  = 1'b1;
          pump_d    = 1'b1;
          elapsed_d = '0;
          run_min_d = default_min_q;
          cnt_d     = count_step(izt_count_t'{mins: start_min, secs: SEC_RELOAD});
        end
      end
      ACT_STOP: begin
        elapsed_d = '0;
        if (item_q.zone == '0) begin
          valves_d = '0;
          active_d = 1'b0;
          pump_d   = 1'b0;
        end else if (32'(item_q.zone) <= NUM_ZONES) begin
          valves_d = stop_valves;
          if (stop_valves == '0) begin
            active_d = 1'b0;
            pump_d   = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SCHED; i++) sched_q[i] <= '0;
      default_min_q <= DEFAULT_MIN_RST;
    end else if (cfg_we_i) begin
      if (32'(cfg_addr_i) < NUM_SCHED) begin
        sched_q[cfg_addr_i[SCHED_IDX_W-1:0]] <= cfg_wdata_i;
      end else if (cfg_addr_i == REG_DEFAULT_MIN) begin
        default_min_q <= cfg_wdata_i[7:0];
      end
    end
  end

  // Run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      valves_q  <= '0;
      pump_q    <= 1'b0;
      elapsed_q <= '0;
      run_min_q <= '0;
      cnt_q     <= '0;
      alert_q   <= ALERT_NONE;
    end else begin
      active_q  <= active_d;
      valves_q  <= valves_d;
      pump_q    <= pump_d;
      elapsed_q <= elapsed_d;
      run_min_q <= run_min_d;
      cnt_q     <= cnt_d;
      alert_q   <= alert_d;
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.act == ACT_LOAD) begin
      op_q   <= op_i;
      item_q <= item_i;
    end
    if (cmd_i.act == ACT_OUT) begin
      out_q.watering_on  <= active_q;
      out_q.valve_mask   <= valves_q;
      out_q.pump_on      <= pump_q;
      out_q.minutes_left <= cnt_q.mins;
      out_q.seconds_left <= cnt_q.secs;
      out_q.alert        <= alert_q;
    end
  end

  assign status_o.op = op_q;
  assign result_o    = out_q;

  `ASSERT_P(a_pump_follows, pump_q == active_q, "pump and run state disagree")
  `ASSERT_P(a_sec_range, cnt_q.secs <= SEC_RELOAD, "seconds field out of range")
  `ASSERT_P(a_run_end, cmd_i.act == ACT_TICK_END && active_q && elapsed_q >= run_limit |=> !active_q && valves_q == '0, "run did not end")

endmodule

/* hw/rtl/irrigation_zone_timer_controller.sv */
// ----------------------------------------------------------------------------
// irrigation_zone_timer_controller
// Four-zone watering controller with pump, run timer and schedules.
// ----------------------------------------------------------------------------
//   channel   dir  handshake                   payload
//   s_axis    in   s_axis_tvalid/s_axis_tready tuser: operation; tdata: item
//   m_axis    out  m_axis_tvalid/m_axis_tready tdata: status
//   cfg       in   cfg_we_i (no wait)          cfg_addr_i, cfg_wdata_i
//
// Per item the sequencer steps from idle through exec to done: manual start,
// key start, stop and unused codes go straight to done; a tick adds the
// end-of-run compare after the count; a schedule check visits the five schedule
// registers, one per cycle. The result loads as the sequencer returns to idle,
// where the next item is taken; a stalled m_axis holds the sequencer in its final state.
// Reset clears run state, schedules (to 0) and default minutes (to 10).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irrigation_zone_timer_controller (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input item channel
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tuser: operation[2:0]
  input  logic [2:0]                         s_axis_tuser,
  // tdata: zone[2:0], duration_minutes[10:3], weekday[13:11], hour_now[18:14],
  //        minute_now[24:19], pesticide_busy[25], biopest_busy[26], zero[31:27]
  input  logic [31:0]                        s_axis_tdata,
  // Result channel
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: watering_on[0], valve_mask[4:1], pump_on[5], minutes_left[13:6],
  //        seconds_left[19:14], alert[21:20], zero[23:22]
  output logic [23:0]                        m_axis_tdata,
  // Configuration writes
  input  logic                               cfg_we_i,
  input  logic [izt_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [izt_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import izt_pkg::*;

  izt_cmd_t    cmd;
  izt_status_t status;
  izt_result_t result;
  izt_item_t   item;

  // Unpack the item; the top pad bits of tdata carry nothing.
  assign item = izt_item_t'(s_axis_tdata[$bits(izt_item_t)-1:0]);

  izt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  izt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_i        (s_axis_tuser),
    .item_i      (item),
    .cmd_i       (cmd),
    .status_o    (status),
    .result_o    (result)
  );

  // Pad the status to whole bytes.
  assign m_axis_tdata = {(24 - $bits(izt_result_t))'(0), result};

endmodule

/* tb/irrigation_zone_timer_controller_test.sv */
// ----------------------------------------------------------------------------
// irrigation_zone_timer_controller_test
// Self-checking bench for the watering controller. A short table of directed
// events comes first, then four phases of random events, each under its own
// set of schedules and key-start duration. Each status transfer is checked
// against a typed status or a cycle-free model of valves, pump, run timer and alerts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irrigation_zone_timer_controller_test;

  import izt_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 7;
  localparam int IDLE_PCT       = 19;
  localparam int PHASES         = 4;
  localparam int PHASE_EVENTS   = 232;
  localparam int STEADY_EVENTS  = 150;
  localparam int SETTLE_CYCLES  = 16;
  localparam int MAX_REPORTS    = 10;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DIRECTED_ROWS  = 26;

  // Codes the block does not decode; it must answer them with a plain status
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  // Schedule registers sit below the default-minutes register
  localparam logic [CFG_ADDR_W-1:0] REG_SCHED_A = '0;
  localparam logic [NUM_ZONES-1:0]  ALL_ZONES   = '1;

  // One directed row: the event, then the status typed in by hand when
  // known_status is set (otherwise the model decides)
  typedef struct packed {
    logic [2:0] op;
    logic [2:0] zone;
    logic [7:0] duration;
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic       pest;
    logic       bio;
    logic       known_status;
    logic       on;
    logic [3:0] valves;
    logic       pump;
    logic [7:0] minutes;
    logic [5:0] seconds;
    logic [1:0] alert;
  } plan_row_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [2:0]            s_axis_tuser  = OP_TICK;
  logic [31:0]           s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [23:0]           m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;

  // Model copy of the registers
  logic [CFG_DATA_W-1:0] sched_cfg [NUM_SCHED] = '{default: '0};
  logic [7:0]            key_minutes = DEFAULT_MIN_RST;

  // Model copy of the run state
  logic                  run_active  = 1'b0;
  logic [NUM_ZONES-1:0]  open_valves = '0;
  logic                  pump_run    = 1'b0;
  logic [13:0]           elapsed_s   = '0;
  logic [7:0]            run_len_min = '0;
  logic [7:0]            cd_min      = '0;
  logic [5:0]            cd_sec      = '0;

  izt_result_t status_queue [$];
  int          fault_count = 0;
  int          cycle_count = 0;
  logic        steady      = 1'b0;

  irrigation_zone_timer_controller i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Watering model
  // --------------------------------------------------------------------------

  function automatic logic [30:0] sched_word(logic [6:0] days, logic [4:0] hr,
                                             logic [5:0] mn, logic [3:0] zones,
                                             logic [7:0] mins);
    return {mins, zones, mn, hr, days, 1'b1};
  endfunction

  // Zone 0 means every zone; a zone beyond the last one opens nothing
  function automatic logic [NUM_ZONES-1:0] zone_select(logic [2:0] z);
    if (z == 3'd0) return ALL_ZONES;
    if (z <= 3'(NUM_ZONES)) return NUM_ZONES'(1) << (z - 3'd1);
    return '0;
  endfunction

  function automatic logic [1:0] refusal(izt_item_t it);
    if (it.pesticide_busy) return ALERT_PEST;
    if (it.biopest_busy) return ALERT_BIO;
    if (run_active) return ALERT_ACTIVE;
    return ALERT_NONE;
  endfunction

  task automatic start_run(input logic [7:0] mins);
    run_active  = 1'b1;
    pump_run    = 1'b1;
    elapsed_s   = '0;
    run_len_min = mins;
    cd_min      = mins - 8'd1;
    cd_sec      = SEC_RELOAD;
  endtask

  task automatic stop_run();
    run_active = 1'b0;
    pump_run   = 1'b0;
  endtask

  // Count down one second; freeze once the minutes reach zero
  task automatic step_countdown();
    if (cd_sec != '0 && cd_min != '0) begin
      cd_sec = cd_sec - 6'd1;
      if (cd_sec == '0) begin
        cd_min = cd_min - 8'd1;
        cd_sec = SEC_RELOAD;
      end
    end
  endtask

  task automatic apply_event(input logic [2:0] op, input izt_item_t it,
                             output izt_result_t status);
    logic [CFG_DATA_W-1:0] word;
    logic [1:0]            alert;
    alert = ALERT_NONE;
    case (op)
      OP_TICK: begin
        if (run_active) begin
          step_countdown();
          elapsed_s = elapsed_s + 14'd1;
          if (elapsed_s >= 14'(run_len_min) * SEC_PER_MIN) begin
            elapsed_s   = '0;
            open_valves = '0;
            stop_run();
          end
        end
      end
      OP_SCHED: begin
        // Later matches overwrite earlier ones; only the first can start a run
        for (int s = 0; s < NUM_SCHED; s++) begin
          word = sched_cfg[s];
          if (word[0] && it.weekday <= 3'd6 && word[1 + it.weekday] &&
              word[12:8] == it.hour_now && word[18:13] == it.minute_now) begin
            open_valves = word[22:19] & ALL_ZONES;
            run_len_min = word[30:23];
            if (!run_active && !it.pesticide_busy && !it.biopest_busy)
              start_run(run_len_min);
          end
        end
      end
      OP_MANUAL: begin
        alert = refusal(it);
        if (alert == ALERT_ACTIVE) begin
          open_valves |= zone_select(it.zone);
        end else if (alert == ALERT_NONE) begin
          start_run(it.duration_minutes);
          open_valves |= zone_select(it.zone);
        end
      end
      OP_KEY: begin
        alert = refusal(it);
        if (alert == ALERT_NONE) begin
          start_run(key_minutes);
          step_countdown();
        end
      end
      OP_STOP: begin
        elapsed_s = '0;
        if (it.zone == 3'd0) begin
          open_valves = '0;
          stop_run();
        end else if (it.zone <= 3'(NUM_ZONES)) begin
          open_valves &= ~zone_select(it.zone);
          if (open_valves == '0) stop_run();
        end
      end
      default: begin
      end
    endcase
    status.watering_on  = run_active;
    status.valve_mask   = open_valves;
    status.pump_on      = pump_run;
    status.minutes_left = cd_min;
    status.seconds_left = cd_sec;
    status.alert        = alert;
  endtask

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Write all six registers back to back from the model copy
  task automatic program_registers();
    for (int i = 0; i <= NUM_SCHED; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= (i == NUM_SCHED) ? REG_DEFAULT_MIN : REG_SCHED_A + CFG_ADDR_W'(i);
      cfg_wdata_i <= (i == NUM_SCHED) ? CFG_DATA_W'(key_minutes) : sched_cfg[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Present one event, hold it until the transfer, then record its status.
  // tvalid stays high on return so the next event can follow without a gap.
  task automatic issue_event(input logic [2:0] op, input izt_item_t it,
                             input logic known, input izt_result_t typed);
    izt_result_t predicted;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, it};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    apply_event(op, it, predicted);
    status_queue.push_back(known ? typed : predicted);
  endtask

  // Drop tvalid and hold off until every status is back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (status_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_event(output logic [2:0] op, output izt_item_t it);
    int pick;
    int s;
    pick = $urandom_range(0, 99);
    it.zone = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, NUM_ZONES));
    // Short durations let runs end on their own within the phase
    it.duration_minutes = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3))
                                                      : 8'($urandom);
    it.weekday        = ($urandom_range(0, 29) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
    it.hour_now       = 5'($urandom_range(0, 23));
    it.minute_now     = 6'($urandom_range(0, 59));
    it.pesticide_busy = ($urandom_range(0, 9) == 0);
    it.biopest_busy   = ($urandom_range(0, 9) == 0);
    if (pick < 48) begin
      op = OP_TICK;
    end else if (pick < 62) begin
      op = OP_SCHED;
      // Mostly aim at the time of a programmed schedule so checks do hit
      if ($urandom_range(0, 99) < 65) begin
        s = $urandom_range(0, NUM_SCHED - 1);
        if (sched_cfg[s][12:8] <= 5'd23 && sched_cfg[s][18:13] <= 6'd59) begin
          it.hour_now   = sched_cfg[s][12:8];
          it.minute_now = sched_cfg[s][18:13];
        end
      end
    end else if (pick < 76) begin
      op = OP_MANUAL;
    end else if (pick < 84) begin
      op = OP_KEY;
    end else if (pick < 97) begin
      op = OP_STOP;
    end else begin
      op = 3'($urandom_range(int'(OP_SPARE_FIRST), int'(OP_SPARE_LAST)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Status checker, result stall and watchdog
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin : status_check
    izt_result_t seen;
    izt_result_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        seen = izt_result_t'(m_axis_tdata[$bits(izt_result_t)-1:0]);
        if (status_queue.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("%0t: status transfer with none pending: %h", $realtime, m_axis_tdata);
        end else begin
          want = status_queue.pop_front();
          if (seen !== want) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
              $display({"%0t: status mismatch exp on=%0d valves=%h pump=%0d min=%0d ",
                        "sec=%0d alert=%0d, got on=%0d valves=%h pump=%0d min=%0d ",
                        "sec=%0d alert=%0d"}, $realtime,
                       want.watering_on, want.valve_mask, want.pump_on,
                       want.minutes_left, want.seconds_left, want.alert,
                       seen.watering_on, seen.valve_mask, seen.pump_on,
                       seen.minutes_left, seen.seconds_left, seen.alert);
          end
        end
      end
      // Stall the status channel at random except in the steady stretch
      m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Directed events
  // --------------------------------------------------------------------------

  // Before these rows schedule A and C fire on weekday 2 at 06:30 (zones 1+3
  // for one minute, then zone 2 for two minutes), schedule E is all ones and
  // key start uses the reset duration of ten minutes.
  plan_row_t directed_plan [DIRECTED_ROWS] = '{
    // op, zone, duration, weekday, hour, minute, pesticide, biopest,
    //   known, on, valves, pump, minutes, seconds, alert
    // idle tick and an undecoded code leave everything at reset
    '{OP_TICK,        3'd0, 8'd0,   3'd0, 5'd0,  6'd0,  1'b0, 1'b0,
      1'b1, 1'b0, 4'h0, 1'b0, 8'd0,   6'd0,  ALERT_NONE},
    '{OP_SPARE_LAST,  3'd0, 8'd0,   3'd0, 5'd0,  6'd0,  1'b0, 1'b0,
      1'b1, 1'b0, 4'h0, 1'b0, 8'd0,   6'd0,  ALERT_NONE},
    // interlocks: pesticide wins over biopesticide
    '{OP_MANUAL,      3'd1, 8'd5,   3'd0, 5'd0,  6'd0,  1'b1, 1'b1,
      1'b1, 1'b0, 4'h0, 1'b0, 8'd0,   6'd0,  ALERT_PEST},
    '{OP_MANUAL,      3'd1, 8'd5,   3'd0, 5'd0,  6'd0,  1'b0, 1'b1,
      1'b1, 1'b0, 4'h0, 1'b0, 8'd0,   6'd0,  ALERT_BIO},
    '{OP_KEY,         3'd0, 8'd0,   3'd0, 5'd0,  6'd0,  1'b1, 1'b0,
      1'b1, 1'b0, 4'h0, 1'b0, 8'd0,   6'd0,  ALERT_PEST},
    // longest manual run on all zones
    '{OP_MANUAL,      3'd0, 8'd255, 3'd0, 5'd0,  6'd0,  1'b0, 1'b0,
      1'b1, 1'b1, 4'hF, 1'b1, 8'd254, 6'd59, ALERT_NONE},
    // repeated starts while watering
    '{OP_MANUAL,      3'd2, 8'd9,   3'd0, 5'd0,  6'd0,  1'b0, 1'b0,
      1'b1, 1'b1, 4'hF, 1'b1, 8'd254, 6'd59, ALERT_ACTIVE},
    '{OP_KEY,         3'd0, 8'd0,   3'd0, 5'd0,  6'd0,  1'b0, 1'b0,
      1'b1, 1'b1, 4'hF, 1'b1, 8'd254, 6'd59, ALERT_ACTIVE},
    '{OP_TICK,        3'd0, 8'd0,   3'd0, 5'd0,  6'd0,  1'b0, 1'b0,
      1'b0, 1'b0, 4'h0, 1'b0, 8'd0,   6'd0,  ALERT_NONE},
    // stop of a zone beyond the last one, then of one zone, then of all
    '{OP_STOP,        3'd5, 8'd0,   3'd0, 5'd0,  6'd0,  1'b0, 1'b0,
      1'b0, 1'b0, 4'h0, 1'b0, 8'd0,   6'd0,  ALERT_NONE},
    '{OP_STOP,        3'd1, 8'd0,   3'd0, 5'd0,  6'd0,  1'b0, 1'b0,
      1'b0, 1'b0, 4'h0, 1'b0, 8'd0,   6'd0,  ALERT_NONE},
    '{OP_STOP,        3'd0, 8'd0,   3'd0, 5'd0,  6'd0,  1'b0, 1'b0,
      1'b1, 1'b0, 4'h0, 1'b0, 8'd254, 6'd58, ALERT_NONE},
    // key start with the reset duration counts one second at once
    '{OP_KEY,         3'd0, 8'd0,   3'd0, 5'd0,  6'd0,  1'b0, 1'b0,
      1'b1, 1'b1, 4'h0, 1'b1, 8'd9,   6'd58, ALERT_NONE},
    // no valve open, so stopping one zone ends the run
    '{OP_STOP,        3'd3, 8'd0,   3'd0, 5'd0,  6'd0,  1'b0, 1'b0,
      1'b0, 1'b0, 4'h0, 1'b0, 8'd0,   6'd0,  ALERT_NONE},
    // zero minutes wraps the countdown and ends on the next tick
    '{OP_MANUAL,      3'd7, 8'd0,   3'd0, 5'd0,  6'd0,  1'b0, 1'b0,
      1'b1, 1'b1, 4'h0, 1'b1, 8'd255, 6'd59, ALERT_NONE},
    '{OP_TICK,        3'd0, 8'd0,   3'd0, 5'd0,  6'd0,  1'b0, 1'b0,
      1'b0, 1'b0, 4'h0, 1'b0, 8'd0,   6'd0,  ALERT_NONE},
    // one minute: countdown freezes at zero minutes
    '{OP_MANUAL,      3'd4, 8'd1,   3'd0, 5'd0,  6'd0,  1'b0, 1'b0,
      1'b0, 1'b0, 4'h0, 1'b0, 8'd0,   6'd0,  ALERT_NONE},
    '{OP_TICK,        3'd0, 8'd0,   3'd0, 5'd0,  6'd0,  1'b0, 1'b0,
      1'b0, 1'b0, 4'h0, 1'b0, 8'd0,   6'd0,  ALERT_NONE},
    // schedule hit during a run overwrites valves without a restart
    '{OP_SCHED,       3'd0, 8'd0,   3'd2, 5'd6,  6'd30, 1'b0, 1'b0,
      1'b0, 1'b0, 4'h0, 1'b0, 8'd0,   6'd0,  ALERT_NONE},
    '{OP_STOP,        3'd0, 8'd0,   3'd0, 5'd0,  6'd0,  1'b0, 1'b0,
      1'b0, 1'b0, 4'h0, 1'b0, 8'd0,   6'd0,  ALERT_NONE},
    // schedule hit under interlock: valves change, no start
    '{OP_SCHED,       3'd0, 8'd0,   3'd2, 5'd6,  6'd30, 1'b1, 1'b0,
      1'b0, 1'b0, 4'h0, 1'b0, 8'd0,   6'd0,  ALERT_NONE},
    // weekday beyond Saturday matches nothing
    '{OP_SCHED,       3'd0, 8'd0,   3'd7, 5'd6,  6'd30, 1'b0, 1'b0,
      1'b0, 1'b0, 4'h0, 1'b0, 8'd0,   6'd0,  ALERT_NONE},
    '{OP_SCHED,       3'd0, 8'd0,   3'd2, 5'd6,  6'd30, 1'b0, 1'b0,
      1'b0, 1'b0, 4'h0, 1'b0, 8'd0,   6'd0,  ALERT_NONE},
    '{OP_SCHED,       3'd0, 8'd0,   3'd6, 5'd23, 6'd59, 1'b0, 1'b0,
      1'b0, 1'b0, 4'h0, 1'b0, 8'd0,   6'd0,  ALERT_NONE},
    // undecoded code with every field at its top and both interlocks set
    '{OP_SPARE_FIRST, 3'd7, 8'd255, 3'd7, 5'd23, 6'd59, 1'b1, 1'b1,
      1'b0, 1'b0, 4'h0, 1'b0, 8'd0,   6'd0,  ALERT_NONE},
    '{OP_MANUAL,      3'd3, 8'd2,   3'd0, 5'd0,  6'd0,  1'b0, 1'b0,
      1'b0, 1'b0, 4'h0, 1'b0, 8'd0,   6'd0,  ALERT_NONE}
  };

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    izt_item_t   it;
    izt_result_t typed;
    logic [2:0]  op;
    plan_row_t   row;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sched_cfg[0] = sched_word(7'b0000100, 5'd6, 6'd30, 4'b0101, 8'd1);
    sched_cfg[2] = sched_word(7'b0000100, 5'd6, 6'd30, 4'b0010, 8'd2);
    sched_cfg[4] = '1;
    program_registers();

    foreach (directed_plan[r]) begin
      row                 = directed_plan[r];
      it.zone             = row.zone;
      it.duration_minutes = row.duration;
      it.weekday          = row.weekday;
      it.hour_now         = row.hour;
      it.minute_now       = row.minute;
      it.pesticide_busy   = row.pest;
      it.biopest_busy     = row.bio;
      typed.watering_on   = row.on;
      typed.valve_mask    = row.valves;
      typed.pump_on       = row.pump;
      typed.minutes_left  = row.minutes;
      typed.seconds_left  = row.seconds;
      typed.alert         = row.alert;
      issue_event(row.op, it, row.known_status, typed);
    end

    // Each phase starts from an idle block: every status back, then new
    // schedules and a new key-start duration, the extremes among them
    for (int p = 0; p < PHASES; p++) begin
      settle();
      for (int s = 0; s < NUM_SCHED; s++) begin
        sched_cfg[s] = sched_word(7'($urandom), 5'($urandom_range(0, 23)),
                                  6'($urandom_range(0, 59)), 4'($urandom),
                                  ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 3))
                                                              : 8'($urandom));
        sched_cfg[s][0] = ($urandom_range(0, 6) != 0);
      end
      case (p)
        0: key_minutes = 8'd1;
        1: begin
          key_minutes  = 8'd0;
          sched_cfg[0] = '1;
        end
        2: begin
          key_minutes  = 8'd255;
          sched_cfg[1] = '0;
        end
        default: key_minutes = 8'd2;
      endcase
      program_registers();

      for (int n = 0; n < PHASE_EVENTS; n++) begin
        // Run the first stretch of phase two with no idling on either side
        if (p == 2 && n == 0) steady <= 1'b1;
        if (p == 2 && n == STEADY_EVENTS) steady <= 1'b0;
        random_event(op, it);
        issue_event(op, it, 1'b0, '0);
      end
    end

    settle();
    if (fault_count == 0 && status_queue.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
